FILE: src/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared widths, register indexes and defaults for the depth pixel
// back-projection unit.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // input item fields
  localparam int DEPTH_W = 16;
  localparam int PIX_FIELD_W = 12;
  localparam int IN_TDATA_W = 40;   // 16 + 12 + 12, already whole bytes

  // result item fields
  localparam int COORD_W = 32;
  localparam int OUT_TDATA_W = 80;  // 32 + 32 + 16
  localparam int OUT_TUSER_W = 2;

  // configuration
  localparam int CENTER_W = 16;
  localparam int RECIP_W = 24;
  localparam int FRAC_SHIFT = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam int COORD_BITS_DEF = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RECIP_FX = 2'd2,
    REG_RECIP_FY = 2'd3
  } cfg_reg_t;

endpackage

FILE: src/depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// Back-projects one depth pixel through a pinhole model into an x/y/z point.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the six-stage pipeline advances whenever
// the output register is empty or being taken, so a stall freezes all stages.
// Reset: synchronous, clears all stage valid bits and the configuration
// registers (centers and focal reciprocals read as zero).
module depth_pixel_backprojection_unit #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_wr_en,
  input  logic [dpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dpb_pkg::IN_TDATA_W-1:0]    s_tdata,   // depth_mm, pixel_col, pixel_row
  // point output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dpb_pkg::OUT_TDATA_W-1:0]   m_tdata,   // point_x, point_y, point_z
  output logic [dpb_pkg::OUT_TUSER_W-1:0]   m_tuser    // point_valid, coord_saturated
);
  import dpb_pkg::*;

  localparam int PIX_W = (COORD_BITS < PIX_FIELD_W) ? COORD_BITS : PIX_FIELD_W;
  localparam int SCALED_W = PIX_W + 4;
  localparam int MAG_W = (SCALED_W > CENTER_W) ? SCALED_W : CENTER_W;
  localparam int MD_W = MAG_W + DEPTH_W;
  localparam int LO_W = MD_W / 2;
  localparam int HI_W = MD_W - LO_W;
  localparam int PROD_W = MD_W + RECIP_W;
  localparam int Q_W = PROD_W + 1 - FRAC_SHIFT;

  localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'((64'd1 << FRAC_SHIFT) - 64'd1);
  localparam logic [Q_W-1:0] Q_POS_MAX = {{(Q_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic [Q_W-1:0] Q_NEG_MAX = {{(Q_W - COORD_W){1'b0}}, 1'b1, {(COORD_W - 1){1'b0}}};
  localparam logic [COORD_W-1:0] S32_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic [COORD_W-1:0] S32_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  // configuration registers
  logic [CENTER_W-1:0] center_x, center_y;
  logic [RECIP_W-1:0]  recip_fx, recip_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      recip_fx <= '0;
      recip_fy <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y: center_y <= cfg_data[CENTER_W-1:0];
        REG_RECIP_FX: recip_fx <= cfg_data[RECIP_W-1:0];
        REG_RECIP_FY: recip_fy <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [DEPTH_W-1:0]     in_depth;
  logic [PIX_FIELD_W-1:0] in_pix [2];
  logic [CENTER_W-1:0]    center [2];
  logic [RECIP_W-1:0]     recip [2];

  assign in_depth  = s_tdata[15:0];
  assign in_pix[0] = s_tdata[27:16];
  assign in_pix[1] = s_tdata[39:28];
  assign center[0] = center_x;
  assign center[1] = center_y;
  assign recip[0]  = recip_fx;
  assign recip[1]  = recip_fy;

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage registers; index 0 is x, 1 is y
  logic               s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic [DEPTH_W-1:0] s1_depth, s2_depth, s3_depth, s4_depth, s5_depth;
  logic [1:0]         s1_neg, s2_neg, s3_neg, s4_neg, s5_neg;
  logic [MAG_W-1:0]   s1_mag [2];
  logic [MD_W-1:0]    s2_md [2];
  logic [LO_W+RECIP_W-1:0] s3_plo [2];
  logic [HI_W+RECIP_W-1:0] s3_phi [2];
  logic [PROD_W-1:0]  s4_prod [2];
  logic [Q_W-1:0]     s5_q [2];

  // stage 1 combinational: |pix*16 - center|
  logic [MAG_W-1:0] scaled [2];
  logic [MAG_W-1:0] cext [2];
  logic [1:0]       neg_c;
  logic [MAG_W-1:0] mag_c [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      scaled[a] = MAG_W'({in_pix[a][PIX_W-1:0], 4'b0000});
      cext[a]   = MAG_W'(center[a]);
      neg_c[a]  = scaled[a] < cext[a];
      mag_c[a]  = neg_c[a] ? (cext[a] - scaled[a]) : (scaled[a] - cext[a]);
    end
  end

  // stage 5 combinational: shift by FRAC_SHIFT, ceiling on negative side
  logic [PROD_W:0] rnd [2];
  logic [Q_W-1:0]  q_c [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rnd[a] = {1'b0, s4_prod[a]} + ROUND_ADD;
      q_c[a] = s4_neg[a] ? rnd[a][PROD_W:FRAC_SHIFT]
                         : {1'b0, s4_prod[a][PROD_W-1:FRAC_SHIFT]};
    end
  end

  // stage 6 combinational: sign, saturation, zero-depth case
  logic [COORD_W-1:0] coord_c [2];
  logic [1:0]         clip_c;
  logic               pt_valid_c;

  always_comb begin
    pt_valid_c = s5_depth != '0;
    for (int a = 0; a < 2; a++) begin
      if (s5_neg[a]) begin
        clip_c[a]  = s5_q[a] > Q_NEG_MAX;
        coord_c[a] = clip_c[a] ? S32_MIN : (COORD_W'(0) - s5_q[a][COORD_W-1:0]);
      end else begin
        clip_c[a]  = s5_q[a] > Q_POS_MAX;
        coord_c[a] = clip_c[a] ? S32_MAX : s5_q[a][COORD_W-1:0];
      end
      if (!pt_valid_c) begin
        clip_c[a]  = 1'b0;
        coord_c[a] = '0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      m_tvalid <= s5_valid;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_depth <= in_depth;
      s1_neg   <= neg_c;
      s2_depth <= s1_depth;
      s2_neg   <= s1_neg;
      s3_depth <= s2_depth;
      s3_neg   <= s2_neg;
      s4_depth <= s3_depth;
      s4_neg   <= s3_neg;
      s5_depth <= s4_depth;
      s5_neg   <= s4_neg;
      for (int a = 0; a < 2; a++) begin
        s1_mag[a]  <= mag_c[a];
        s2_md[a]   <= MD_W'(s1_mag[a]) * MD_W'(s1_depth);
        // split the recip product into two half-width multiplies
        s3_plo[a]  <= (LO_W+RECIP_W)'(s2_md[a][LO_W-1:0]) * (LO_W+RECIP_W)'(recip[a]);
        s3_phi[a]  <= (HI_W+RECIP_W)'(s2_md[a][MD_W-1:LO_W]) * (HI_W+RECIP_W)'(recip[a]);
        s4_prod[a] <= (PROD_W'(s3_phi[a]) << LO_W) + PROD_W'(s3_plo[a]);
        s5_q[a]    <= q_c[a];
      end
      m_tdata <= {s5_depth & {DEPTH_W{pt_valid_c}}, coord_c[1], coord_c[0]};
      m_tuser <= {clip_c[0] | clip_c[1], pt_valid_c};
    end
  end

`ifndef SYNTH
  // an invalid point carries zero coordinates and no clip flag
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("invalid point with nonzero payload");

  // a clipped point has at least one coordinate at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      (m_tdata[31:0] == S32_MAX) || (m_tdata[31:0] == S32_MIN) ||
      (m_tdata[63:32] == S32_MAX) || (m_tdata[63:32] == S32_MIN))
    else $error("clip flag set without saturated coordinate");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s1_valid && !s5_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

FILE: tb/dpb_point_checker.sv
// ----------------------------------------------------------------------------
// dpb_point_checker
// Watches the config port and both stream channels of the back-projection
// unit. For each accepted pixel it computes the expected 3-D point from its
// own copy of the camera registers. Each point the unit delivers is checked
// field by field against the oldest expected point.
// ----------------------------------------------------------------------------
module dpb_point_checker #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [dpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [dpb_pkg::IN_TDATA_W-1:0]    s_tdata,   // depth_mm, pixel_col, pixel_row
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [dpb_pkg::OUT_TDATA_W-1:0]   m_tdata,   // point_x, point_y, point_z
  input  logic [dpb_pkg::OUT_TUSER_W-1:0]   m_tuser,   // point_valid, coord_saturated
  output int                                errors,
  output int                                pending
);
  import dpb_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] z;
    logic        valid;
    logic        sat;
  } point_t;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic [15:0] cam_cx;
  logic [15:0] cam_cy;
  logic [23:0] cam_rfx;
  logic [23:0] cam_rfy;

  point_t expected_points[$];

  // returns {clipped, coord}
  function automatic logic [32:0] axis_coord(input logic [11:0] pix,
                                             input logic [15:0] center,
                                             input logic [15:0] depth,
                                             input logic [23:0] recip);
    longint scaled, c, d, r, prod, q;
    scaled = longint'(pix);
    scaled = (scaled & ((64'sd1 << COORD_BITS) - 1)) << 4;
    c = longint'(center);
    d = longint'(depth);
    r = longint'(recip);
    prod = (scaled - c) * d * r;   // |prod| < 2^56, exact
    q = prod >>> FRAC_SHIFT;       // floor
    if (q > S32_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (q < S32_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, q[31:0]};
  endfunction

  function automatic point_t backproject_pixel(input logic [15:0] depth,
                                               input logic [11:0] col,
                                               input logic [11:0] row);
    point_t p;
    logic [32:0] ax, ay;
    p = '0;
    if (depth == 16'd0) return p;
    ax = axis_coord(col, cam_cx, depth, cam_rfx);
    ay = axis_coord(row, cam_cy, depth, cam_rfy);
    p.x = ax[31:0];
    p.y = ay[31:0];
    p.z = depth;
    p.valid = 1'b1;
    p.sat = ax[32] | ay[32];
    return p;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      expected_points.delete();
      cam_cx = '0;
      cam_cy = '0;
      cam_rfx = '0;
      cam_rfy = '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X: cam_cx = cfg_data[CENTER_W-1:0];
          REG_CENTER_Y: cam_cy = cfg_data[CENTER_W-1:0];
          REG_RECIP_FX: cam_rfx = cfg_data[RECIP_W-1:0];
          REG_RECIP_FY: cam_rfy = cfg_data[RECIP_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point item: expected none, got %0h/%0h",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_points.pop_front();
          check_field("point_x", want.x, m_tdata[31:0]);
          check_field("point_y", want.y, m_tdata[63:32]);
          check_field("point_z", 32'(want.z), 32'(m_tdata[79:64]));
          check_field("point_valid", 32'(want.valid), 32'(m_tuser[0]));
          check_field("coord_saturated", 32'(want.sat), 32'(m_tuser[1]));
        end
      end
      if (s_tvalid && s_tready)
        expected_points.push_back(backproject_pixel(s_tdata[15:0], s_tdata[27:16],
                                                    s_tdata[39:28]));
    end
    pending = expected_points.size();
  end

endmodule

FILE: tb/tb_depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection_unit
// Drives depth pixels and camera settings into the back-projection unit:
// a directed set of corner pixels (zero depth, extremes, saturation, unset
// focal reciprocals), then random pixels under several camera setups and
// three sender/receiver idling mixes. Checking lives in dpb_point_checker.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection_unit;
  import dpb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_CAMERA = 125;
  localparam int DRAIN_CYCLES = 12;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic [OUT_TUSER_W-1:0]  m_tuser;

  int errors;
  int pending;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  depth_pixel_backprojection_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  dpb_point_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_pixel(input logic [15:0] depth, input logic [11:0] col,
                            input logic [11:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row, col, depth};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // wait until every point is out and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_camera(input logic [23:0] cx, input logic [23:0] cy,
                            input logic [23:0] rfx, input logic [23:0] rfy);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CENTER_X;
    cfg_data <= cx;
    @(negedge clk);
    cfg_index <= REG_CENTER_Y;
    cfg_data <= cy;
    @(negedge clk);
    cfg_index <= REG_RECIP_FX;
    cfg_data <= rfx;
    @(negedge clk);
    cfg_index <= REG_RECIP_FY;
    cfg_data <= rfy;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // centers get random upper bits now and then; the unit keeps only 16
  task automatic pick_camera(input int mode);
    logic [23:0] cx, cy, rfx, rfy;
    case (mode)
      0: begin  // plausible sensor
        cx = 24'($urandom_range(40000, 1000));
        cy = 24'($urandom_range(40000, 1000));
        rfx = 24'((1 << 24) / $urandom_range(2000, 200));
        rfy = 24'((1 << 24) / $urandom_range(2000, 200));
      end
      1: begin
        cx = 24'($urandom());
        cy = 24'($urandom());
        rfx = 24'($urandom());
        rfy = 24'($urandom());
      end
      2: begin  // corners of the register ranges
        cx = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
        cy = $urandom_range(1) ? 24'h00_FFFF : 24'h0;
        rfx = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
        rfy = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
      end
      default: begin  // tiny reciprocals, rounding near zero
        cx = 24'($urandom_range(65535));
        cy = 24'($urandom_range(65535));
        rfx = 24'($urandom_range(255));
        rfy = 24'($urandom_range(255));
      end
    endcase
    set_camera(cx, cy, rfx, rfy);
  endtask

  function automatic logic [11:0] rand_pix();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [15:0] depth;
    case ($urandom_range(9))
      0: depth = 16'd0;
      1: depth = 16'hFFFF;
      2: depth = 16'($urandom_range(15, 1));
      default: depth = 16'($urandom_range(65535));
    endcase
    send_pixel(depth, rand_pix(), rand_pix());
  endtask

  initial begin
    cycles = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    send_idle_pct = 23;
    recv_stall_pct = 85;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers still at reset: focal reciprocals zero
    send_pixel(16'd0, 12'd0, 12'd0);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    send_pixel(16'd1, 12'd0, 12'd0);
    settle();

    // typical VGA camera, f = 600 px
    set_camera(24'd5120, 24'd3840, 24'd27962, 24'd27962);
    send_pixel(16'd0, 12'd100, 12'd200);
    send_pixel(16'd1000, 12'd320, 12'd240);
    send_pixel(16'd1000, 12'd0, 12'd0);
    send_pixel(16'd1000, 12'hFFF, 12'hFFF);
    send_pixel(16'hFFFF, 12'd0, 12'hFFF);
    send_pixel(16'd1, 12'd321, 12'd239);
    send_pixel(16'hFFFF, 12'hFFF, 12'd0);
    settle();

    // full-scale reciprocals: x clips high, y clips low
    set_camera(24'd0, 24'h00_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'd0);
    send_pixel(16'hFFFF, 12'd0, 12'hFFF);
    send_pixel(16'd1, 12'hFFF, 12'hFFF);
    send_pixel(16'hFFFF, 12'd2048, 12'd2048);
    send_pixel(16'd40000, 12'hFFF, 12'd0);
    settle();

    // center written with junk above bit 15
    set_camera(24'hFF_FFFF, 24'hAB_0000, 24'hFF_FFFF, 24'hFF_FFFF);
    send_pixel(16'hFFFF, 12'd0, 12'hFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 23; recv_stall_pct = 85; end
        1: begin send_idle_pct = 85; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int cam = 0; cam < 4; cam++) begin
        pick_camera(cam);
        repeat (ITEMS_PER_CAMERA) send_random_pixel();
        settle();
      end
    end

    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
